@@ hw/rtl/tasp_pkg.sv @@
package tasp_pkg;

  // sizes of the stores
  localparam int MAX_TILES    = 8;
  localparam int MAX_EDGE_LEN = 4;
  localparam int MAX_MAP_SIZE = 64;
  localparam int SYMBOL_WIDTH = 8;
  localparam int NUM_SIDES    = 4;

  // port field widths
  localparam int TILE_W   = 3;
  localparam int SIDE_W   = 2;
  localparam int POS_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int RAND_W   = 15;
  localparam int TC_W     = 4;
  localparam int EL_W     = 3;
  localparam int MS_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // derived internal widths
  localparam int TILE_IDX_W = $clog2(MAX_TILES);
  localparam int CNT_W      = $clog2(MAX_TILES + 1);
  localparam int COL_W      = $clog2(MAX_MAP_SIZE);
  localparam int LANE_W     = (MAX_EDGE_LEN > 1) ? $clog2(MAX_EDGE_LEN) : 1;
  localparam int EDGE_ROWS  = MAX_TILES * NUM_SIDES;
  localparam int ROW_ADDR_W = $clog2(EDGE_ROWS);
  localparam int ROW_W      = MAX_EDGE_LEN * SYMBOL_WIDTH;

  // remainder unit: MOD_DIGIT bits of the random value per step
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = (RAND_W + MOD_DIGIT - 1) / MOD_DIGIT;
  localparam int RND_PAD_W = MOD_STEPS * MOD_DIGIT;
  localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // side codes
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd3;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PLACE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE    = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_we;
    logic start;
    logic ref_rd;
    logic ref_cap;
    logic scan;
    logic mod_step;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic mod_last;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/tile_adjacency_scanline_placer.sv @@
// Tile adjacency scanline placer.
// Input channel (in_valid/in_ready): mode 0 writes one edge symbol of one
// tile side and gives no result; mode 1 places the next map cell in raster
// order and gives one result on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; the user must see that it is written only while the block is idle;
// the block itself does not enforce this. A load transaction writes the edge
// memory when it is accepted. A place transaction reads the tile above at
// acceptance, fetches the reference edge rows (S_ABOVE, S_REF), reads the
// edge memory once per candidate tile, takes four remainder steps and
// registers the result. No transaction is accepted until a place transaction
// has finished, so cells are paced by the candidate scan over the edge memory.
// A finished result waits in the output register while loads and the next
// place transaction are taken; a place transaction holds in its last step
// until the output register is free.
// Synchronous reset clears map position, left neighbor and output valid and
// restores the configuration registers; edge symbols and the row above are
// undefined until written.
module tile_adjacency_scanline_placer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [tasp_pkg::TILE_W-1:0]        in_tile_index,
  input  logic [tasp_pkg::SIDE_W-1:0]        in_side,
  input  logic [tasp_pkg::POS_W-1:0]         in_edge_position,
  input  logic [tasp_pkg::SYM_IN_W-1:0]      in_edge_symbol,
  input  logic [tasp_pkg::RAND_W-1:0]        in_random_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tasp_pkg::TILE_W-1:0]        out_tile_id,
  output logic                              out_no_candidate,
  output logic                              out_end_of_row,
  output logic                              out_end_of_map,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tasp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tasp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tasp_pkg::*;

  logic [TC_W-1:0]  tile_count_r;
  logic [EL_W-1:0]  edge_length_r;
  logic [MS_W-1:0]  map_size_r;
  logic [CNT_W-1:0] tc;
  logic [EL_W-1:0]  el;
  logic [MS_W-1:0]  size;
  cmd_t             cmd;
  stat_t            stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_count_r  <= TC_W'(8);
      edge_length_r <= EL_W'(1);
      map_size_r    <= MS_W'(24);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TILE_COUNT:  tile_count_r  <= cfg_data[TC_W-1:0];
        CFG_EDGE_LENGTH: edge_length_r <= cfg_data[EL_W-1:0];
        CFG_MAP_SIZE:    map_size_r    <= cfg_data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturate registers into their ranges
  always_comb begin
    if (tile_count_r == '0) tc = CNT_W'(1);
    else if (32'(tile_count_r) > MAX_TILES) tc = CNT_W'(MAX_TILES);
    else tc = CNT_W'(tile_count_r);

    if (edge_length_r == '0) el = EL_W'(1);
    else if (32'(edge_length_r) > MAX_EDGE_LEN) el = EL_W'(MAX_EDGE_LEN);
    else el = edge_length_r;

    if (map_size_r == '0) size = MS_W'(1);
    else if (32'(map_size_r) > MAX_MAP_SIZE) size = MS_W'(MAX_MAP_SIZE);
    else size = map_size_r;
  end

  // controller
  tasp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tasp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_tile_index    (in_tile_index),
    .in_side          (in_side),
    .in_edge_position (in_edge_position),
    .in_edge_symbol   (in_edge_symbol),
    .in_random_value  (in_random_value),
    .tc               (tc),
    .el               (el),
    .size             (size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_id      (out_tile_id),
    .out_no_candidate (out_no_candidate),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_map   (out_end_of_map)
  );

endmodule

@@ hw/rtl/tasp_ctrl.sv @@
module tasp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  input  tasp_pkg::stat_t stat,
  output tasp_pkg::cmd_t  cmd
);
  import tasp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABOVE,
    S_REF,
    S_SCAN,
    S_MOD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          if (in_mode == MODE_PLACE) begin
            cmd.start = 1'b1;
            state_nxt = S_ABOVE;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_ABOVE: begin
        cmd.ref_rd = 1'b1;
        state_nxt  = S_REF;
      end
      S_REF: begin
        cmd.ref_cap = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

@@ hw/rtl/tasp_dp.sv @@
module tasp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tasp_pkg::cmd_t               cmd,
  output tasp_pkg::stat_t              stat,
  input  logic [tasp_pkg::TILE_W-1:0]   in_tile_index,
  input  logic [tasp_pkg::SIDE_W-1:0]   in_side,
  input  logic [tasp_pkg::POS_W-1:0]    in_edge_position,
  input  logic [tasp_pkg::SYM_IN_W-1:0] in_edge_symbol,
  input  logic [tasp_pkg::RAND_W-1:0]   in_random_value,
  input  logic [tasp_pkg::CNT_W-1:0]    tc,
  input  logic [tasp_pkg::EL_W-1:0]     el,
  input  logic [tasp_pkg::MS_W-1:0]     size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tasp_pkg::TILE_W-1:0]   out_tile_id,
  output logic                         out_no_candidate,
  output logic                         out_end_of_row,
  output logic                         out_end_of_map
);
  import tasp_pkg::*;

  // edge symbol memory, one row per tile side, one lane per position
  logic [ROW_W-1:0]      edge_mem [EDGE_ROWS];
  logic [ROW_W-1:0]      rd_a_q, rd_b_q;
  logic [ROW_ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [LANE_W-1:0]     wr_lane;
  logic                  load_ok;

  // tiles placed in the previous row
  logic [TILE_IDX_W-1:0] row_above [MAX_MAP_SIZE];
  logic [TILE_IDX_W-1:0] rab_q;

  // placement state
  logic [TILE_IDX_W-1:0] left_tile_r;
  logic [COL_W-1:0]      col_r, row_r;

  // scan registers
  logic [ROW_W-1:0]      ref_right_r, ref_bottom_r;
  logic [TILE_IDX_W-1:0] cmp_t_r, scan_tile;
  logic [TILE_IDX_W-1:0] cands_r [MAX_TILES];
  logic [CNT_W-1:0]      cnt_r;
  logic                  left_ok, top_ok, match;

  // remainder unit
  logic [RND_PAD_W-1:0]  rnd_r;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0]  mod_cnt_r;

  // result
  logic                  none;
  logic [TILE_IDX_W-1:0] chosen;
  logic                  eor, eom;
  logic                  out_valid_r;
  logic [TILE_W-1:0]     out_tile_id_r;
  logic                  out_none_r, out_eor_r, out_eom_r;

  // load address
  assign load_ok = (32'(in_tile_index) < MAX_TILES) && (32'(in_edge_position) < MAX_EDGE_LEN);
  assign wr_addr = {in_tile_index[TILE_IDX_W-1:0], in_side};
  assign wr_lane = LANE_W'(in_edge_position);

  // read address select
  always_comb begin
    scan_tile = cmd.ref_cap ? '0 : cmp_t_r + 1'b1;
    if (cmd.ref_rd) begin
      rd_addr_a = {left_tile_r, SIDE_RIGHT};
      rd_addr_b = {rab_q, SIDE_BOTTOM};
    end else begin
      rd_addr_a = {scan_tile, SIDE_LEFT};
      rd_addr_b = {scan_tile, SIDE_TOP};
    end
  end

  // edge memory ports
  always_ff @(posedge clk) begin
    if (cmd.load_we && load_ok) begin
      edge_mem[wr_addr][wr_lane*SYMBOL_WIDTH +: SYMBOL_WIDTH] <=
        in_edge_symbol[SYMBOL_WIDTH-1:0];
    end
    rd_a_q <= edge_mem[rd_addr_a];
    rd_b_q <= edge_mem[rd_addr_b];
  end

  // row above memory ports
  always_ff @(posedge clk) begin
    if (cmd.finish) row_above[col_r] <= chosen;
    rab_q <= row_above[col_r];
  end

  // side comparison over the positions in use
  always_comb begin
    logic [MAX_EDGE_LEN-1:0] l_hit, t_hit;
    for (int k = 0; k < MAX_EDGE_LEN; k++) begin
      l_hit[k] = (rd_a_q[k*SYMBOL_WIDTH +: SYMBOL_WIDTH] ==
                  ref_right_r[k*SYMBOL_WIDTH +: SYMBOL_WIDTH]) || (k >= int'(el));
      t_hit[k] = (rd_b_q[k*SYMBOL_WIDTH +: SYMBOL_WIDTH] ==
                  ref_bottom_r[k*SYMBOL_WIDTH +: SYMBOL_WIDTH]) || (k >= int'(el));
    end
    left_ok = (col_r == '0) || (&l_hit);
    top_ok  = (row_r == '0) || (&t_hit);
    match   = left_ok && top_ok;
  end

  // remainder step: MOD_DIGIT restoring steps
  always_comb begin
    logic [CNT_W:0]   sh;
    logic [CNT_W-1:0] rw;
    rw = rem_r;
    for (int i = 0; i < MOD_DIGIT; i++) begin
      sh = {rw, rnd_r[RND_PAD_W-1-i]};
      if (sh >= {1'b0, cnt_r}) sh = sh - {1'b0, cnt_r};
      rw = sh[CNT_W-1:0];
    end
    rem_nxt = rw;
  end

  // candidate choice and position update
  assign none   = (cnt_r == '0);
  assign chosen = none ? '0 : cands_r[rem_r[TILE_IDX_W-1:0]];
  assign eor    = ((MS_W'(col_r) + 1'b1) >= size);
  assign eom    = eor && ((MS_W'(row_r) + 1'b1) >= size);

  // scan and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rnd_r     <= RND_PAD_W'(in_random_value);
      cnt_r     <= '0;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end
    if (cmd.ref_cap) begin
      ref_right_r  <= rd_a_q;
      ref_bottom_r <= rd_b_q;
      cmp_t_r      <= '0;
    end
    if (cmd.scan) begin
      cmp_t_r <= cmp_t_r + 1'b1;
      if (match) begin
        cands_r[cnt_r[TILE_IDX_W-1:0]] <= cmp_t_r;
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.mod_step) begin
      rem_r     <= rem_nxt;
      rnd_r     <= rnd_r << MOD_DIGIT;
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_tile_id_r <= TILE_W'(chosen);
      out_none_r    <= none;
      out_eor_r     <= eor;
      out_eom_r     <= eom;
    end
  end

  // map position, left neighbor and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_tile_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        left_tile_r <= chosen;
        if (eor) begin
          col_r <= '0;
          row_r <= eom ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // status
  assign stat.scan_last = (CNT_W'(cmp_t_r) == tc - 1'b1);
  assign stat.mod_last  = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_tile_id      = out_tile_id_r;
  assign out_no_candidate = out_none_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_map   = out_eom_r;

endmodule

@@ tb/placer_checker.sv @@
`timescale 1ns / 100ps

module placer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_mode,
  input  logic [tasp_pkg::TILE_W-1:0]     in_tile_index,
  input  logic [tasp_pkg::SIDE_W-1:0]     in_side,
  input  logic [tasp_pkg::POS_W-1:0]      in_edge_position,
  input  logic [tasp_pkg::SYM_IN_W-1:0]   in_edge_symbol,
  input  logic [tasp_pkg::RAND_W-1:0]     in_random_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tasp_pkg::TILE_W-1:0]     out_tile_id,
  input  logic                           out_no_candidate,
  input  logic                           out_end_of_row,
  input  logic                           out_end_of_map,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tasp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tasp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             cells_pending,
  output int                             cur_map_row
);
  import tasp_pkg::*;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic              none;
    logic              eor;
    logic              eom;
  } cell_result_t;

  // mirrored block state
  logic [SYMBOL_WIDTH-1:0] edge_sym [MAX_TILES][NUM_SIDES][MAX_EDGE_LEN];
  logic [TILE_W-1:0]       above_row [MAX_MAP_SIZE];
  logic [TILE_W-1:0]       prev_tile;
  int                      cur_col;
  int                      cur_row;

  // mirrored configuration, raw register contents
  logic [TC_W-1:0] tc_reg;
  logic [EL_W-1:0] el_reg;
  logic [MS_W-1:0] ms_reg;

  cell_result_t expected_cells [$];
  int           mismatch_count = 0;

  assign fail_count = mismatch_count;

  function automatic int saturate(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // side sa of tile ta against side sb of tile tb over the used positions
  function automatic bit edges_match(input int ta, input int sa, input int tb, input int sb,
                                     input int elen);
    for (int k = 0; k < elen; k++) begin
      if (edge_sym[ta][sa][k] != edge_sym[tb][sb][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // place the next map cell and advance the raster position
  function automatic cell_result_t next_cell(input logic [RAND_W-1:0] rnd);
    int                tcnt;
    int                elen;
    int                msz;
    int                nfit;
    logic [TILE_W-1:0] fits [MAX_TILES];
    logic [TILE_W-1:0] above;
    logic [TILE_W-1:0] chosen;
    cell_result_t      res;
    tcnt  = saturate(int'(tc_reg), 1, MAX_TILES);
    elen  = saturate(int'(el_reg), 1, MAX_EDGE_LEN);
    msz   = saturate(int'(ms_reg), 1, MAX_MAP_SIZE);
    above = above_row[cur_col];
    nfit  = 0;
    // candidates in ascending tile order
    for (int t = 0; t < tcnt; t++) begin
      if ((cur_col == 0 || edges_match(prev_tile, SIDE_RIGHT, t, SIDE_LEFT, elen)) &&
          (cur_row == 0 || edges_match(above, SIDE_BOTTOM, t, SIDE_TOP, elen))) begin
        fits[nfit] = TILE_W'(t);
        nfit++;
      end
    end
    res.none = (nfit == 0);
    if (res.none) begin
      chosen = '0;
    end else begin
      chosen = fits[int'(rnd) % nfit];
    end
    prev_tile          = chosen;
    above_row[cur_col] = chosen;
    res.tile = chosen;
    // a column or row beyond a shrunk map ends it at once
    res.eor  = (cur_col + 1 >= msz);
    res.eom  = res.eor && (cur_row + 1 >= msz);
    if (res.eor) begin
      cur_col = 0;
      cur_row = res.eom ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns cell result %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      prev_tile = '0;
      cur_col   = 0;
      cur_row   = 0;
      tc_reg    = 4'd8;
      el_reg    = 3'd1;
      ms_reg    = 7'd24;
      expected_cells.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        got = '{tile: out_tile_id, none: out_no_candidate, eor: out_end_of_row,
                eom: out_end_of_map};
        if (expected_cells.size() == 0) begin
          report_mismatch("with nothing outstanding, tile_id", int'(got.tile), -1);
        end else begin
          want = expected_cells.pop_front();
          if (got.tile != want.tile)
            report_mismatch("tile_id", int'(got.tile), int'(want.tile));
          if (got.none != want.none)
            report_mismatch("no_candidate", int'(got.none), int'(want.none));
          if (got.eor != want.eor)
            report_mismatch("end_of_row", int'(got.eor), int'(want.eor));
          if (got.eom != want.eom)
            report_mismatch("end_of_map", int'(got.eom), int'(want.eom));
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TILE_COUNT:  tc_reg = cfg_data[TC_W-1:0];
          CFG_EDGE_LENGTH: el_reg = cfg_data[EL_W-1:0];
          CFG_MAP_SIZE:    ms_reg = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      // input transaction: load a symbol or predict a placed cell
      if (in_valid && in_ready) begin
        if (in_mode == MODE_LOAD) begin
          edge_sym[in_tile_index][in_side][in_edge_position] = in_edge_symbol;
        end else begin
          expected_cells = {expected_cells, next_cell(in_random_value)};
        end
      end
    end
    cells_pending <= expected_cells.size();
    cur_map_row   <= cur_row;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tasp_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 88;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_mode          = MODE_LOAD;
  logic [TILE_W-1:0]     in_tile_index    = '0;
  logic [SIDE_W-1:0]     in_side          = '0;
  logic [POS_W-1:0]      in_edge_position = '0;
  logic [SYM_IN_W-1:0]   in_edge_symbol   = '0;
  logic [RAND_W-1:0]     in_random_value  = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [TILE_W-1:0]     out_tile_id;
  logic                  out_no_candidate;
  logic                  out_end_of_row;
  logic                  out_end_of_map;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_TILE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int fail_count;
  int cells_pending;
  int cur_map_row;

  // map size in effect, saturated; starts at the reset value
  int   map_cells = 24;
  logic steady    = 1'b0;

  // receiver pacing
  int   rx_left;
  int   rx_count;
  logic rx_on;
  logic hold_done;

  always #4 clk = ~clk;

  tile_adjacency_scanline_placer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_tile_index    (in_tile_index),
    .in_side          (in_side),
    .in_edge_position (in_edge_position),
    .in_edge_symbol   (in_edge_symbol),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_id      (out_tile_id),
    .out_no_candidate (out_no_candidate),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_map   (out_end_of_map),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  placer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_tile_index    (in_tile_index),
    .in_side          (in_side),
    .in_edge_position (in_edge_position),
    .in_edge_symbol   (in_edge_symbol),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_id      (out_tile_id),
    .out_no_candidate (out_no_candidate),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_map   (out_end_of_map),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .cells_pending    (cells_pending),
    .cur_map_row      (cur_map_row)
  );

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int send_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // one input transaction; valid stays up until accepted
  task automatic send_txn(input logic mode, input logic [TILE_W-1:0] tile,
                          input logic [SIDE_W-1:0] side, input logic [POS_W-1:0] pos,
                          input logic [SYM_IN_W-1:0] symbol, input logic [RAND_W-1:0] rnd);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_tile_index    <= tile;
    in_side          <= side;
    in_edge_position <= pos;
    in_edge_symbol   <= symbol;
    in_random_value  <= rnd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_symbol(input logic [TILE_W-1:0] tile, input logic [SIDE_W-1:0] side,
                             input logic [POS_W-1:0] pos, input logic [SYM_IN_W-1:0] symbol);
    send_txn(MODE_LOAD, tile, side, pos, symbol, RAND_W'($urandom));
  endtask

  // unused load fields carry random content on a place
  task automatic place_cell(input logic [RAND_W-1:0] rnd);
    send_txn(MODE_PLACE, TILE_W'($urandom), SIDE_W'($urandom), POS_W'($urandom),
             SYM_IN_W'($urandom), rnd);
  endtask

  // stop sending and wait out every outstanding cell
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (cells_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] tc, input logic [CFG_DATA_W-1:0] el,
                            input logic [CFG_DATA_W-1:0] ms);
    int new_size;
    wait_idle();
    new_size = (ms == 0) ? 1 : ((int'(ms) > MAX_MAP_SIZE) ? MAX_MAP_SIZE : int'(ms));
    // growing below row 0 would read columns never placed above: wrap the map first
    if (new_size > map_cells && cur_map_row != 0) begin
      write_reg(CFG_MAP_SIZE, 7'd1);
      place_cell(RAND_W'($urandom));
      wait_idle();
    end
    write_reg(CFG_TILE_COUNT, tc);
    write_reg(CFG_EDGE_LENGTH, el);
    write_reg(CFG_MAP_SIZE, ms);
    map_cells = new_size;
  endtask

  // receiver: random ready runs, one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left   = 0;
      rx_count  = 0;
      rx_on     = 1'b0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count++;
      if (!hold_done && rx_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rx_on     = 1'b0;
        rx_left   = HOLD_CYCLES;
      end else if (rx_left == 0) begin
        rx_on = !rx_on;
        if (rx_on) begin
          rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 20);
        end else begin
          rx_left = idle_len();
        end
      end
      rx_left--;
      out_ready <= rx_on;
    end
  end

  // run limit
  initial begin
    #6000000;
    $display("tile_adjacency_scanline_placer: mismatch");
    $finish;
  end

  initial begin
    logic [SYM_IN_W-1:0]   sym_mask;
    logic [CFG_DATA_W-1:0] tc_val;
    logic [CFG_DATA_W-1:0] el_val;
    logic [CFG_DATA_W-1:0] ms_val;
    int                    pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // write every symbol once so no later read hits an empty entry
    for (int t = 0; t < MAX_TILES; t++)
      for (int s = 0; s < NUM_SIDES; s++)
        for (int p = 0; p < MAX_EDGE_LEN; p++)
          load_symbol(TILE_W'(t), SIDE_W'(s), POS_W'(p), SYM_IN_W'($urandom_range(0, 1)));

    // first cell picks among all tiles with the lowest random value; the next uses the highest
    place_cell('0);
    place_cell({RAND_W{1'b1}});
    // load field extremes
    load_symbol(3'd7, SIDE_LEFT, 2'd3, 8'hFF);
    load_symbol(3'd0, SIDE_TOP, 2'd0, 8'h00);
    place_cell(RAND_W'($urandom));
    place_cell(RAND_W'($urandom));

    // out of range registers saturate to the maximum and minimum
    set_config(7'h7F, 7'd0, 7'h7F);
    place_cell(RAND_W'($urandom));
    place_cell(RAND_W'($urandom));

    // one tile that never fits beside itself; the map shrinks under the column
    set_config(7'd1, 7'd1, 7'd3);
    load_symbol(3'd0, SIDE_RIGHT, 2'd0, 8'd0);
    load_symbol(3'd0, SIDE_LEFT, 2'd0, 8'd1);
    repeat (4) place_cell(RAND_W'($urandom));

    // zero registers: one tile, one-cell map, longest edge
    set_config(7'd0, 7'h7F, 7'd0);
    place_cell(RAND_W'($urandom));
    place_cell(RAND_W'($urandom));

    set_config(7'd8, 7'd4, 7'd64);
    repeat (3) place_cell(RAND_W'($urandom));

    // random phases, each with its own settings and symbol alphabet
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0:       sym_mask = 8'h00;
        1, 2:    sym_mask = 8'h01;
        3:       sym_mask = 8'h03;
        default: sym_mask = 8'hFF;
      endcase
      tc_val = CFG_DATA_W'($urandom_range(0, 127));
      el_val = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                           : CFG_DATA_W'($urandom_range(1, 2));
      pick = $urandom_range(0, 9);
      if (pick < 6)       ms_val = CFG_DATA_W'($urandom_range(1, 6));
      else if (pick < 8)  ms_val = CFG_DATA_W'($urandom_range(7, 16));
      else if (pick == 8) ms_val = '0;
      else                ms_val = CFG_DATA_W'($urandom_range(17, 127));
      set_config(tc_val, el_val, ms_val);
      steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          load_symbol(TILE_W'($urandom), SIDE_W'($urandom), POS_W'($urandom),
                      SYM_IN_W'($urandom) & sym_mask);
        end else begin
          place_cell(RAND_W'($urandom));
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tile_adjacency_scanline_placer: match");
    end else begin
      $display("tile_adjacency_scanline_placer: mismatch");
    end
    $finish;
  end

endmodule
